### sv/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// Shared widths, register indexes and reset values of the isolated cell fill
// filter.
// ----------------------------------------------------------------------------
package icf_pkg;

    // Payload widths
    localparam int CELL_W     = 8;
    localparam int ROW_W      = 16;
    localparam int COL_OUT_W  = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int GRID_WIDTH_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // Reset values of the grid registers
    localparam int GRID_WIDTH_RST  = 80;
    localparam int GRID_HEIGHT_RST = 24;

    // Line buffer depth
    localparam int DEF_MAX_WIDTH = 256;

endpackage

### sv/icf_line_buf.sv
// ----------------------------------------------------------------------------
// icf_line_buf
// Two line buffers: the original cells of the previous row and the filtered
// cells of the row before it. Reads are registered and happen when an item
// is accepted; the original row is read one column ahead.
// ----------------------------------------------------------------------------
module icf_line_buf #(
    parameter int MAX_WIDTH = icf_pkg::DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_acc,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_nxt_addr,
    input  logic [icf_pkg::CELL_W-1:0] i_cell,
    input  logic                       i_fwe,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_faddr,
    input  logic [icf_pkg::CELL_W-1:0] i_fdata,
    output logic [icf_pkg::CELL_W-1:0] o_up,
    output logic [icf_pkg::CELL_W-1:0] o_right
);
    import icf_pkg::*;

    logic [CELL_W-1:0] r_orig_mem [MAX_WIDTH];
    logic [CELL_W-1:0] r_filt_mem [MAX_WIDTH];
    logic [CELL_W-1:0] r_up;
    logic [CELL_W-1:0] r_right;

    // Original row: write the new cell, read one column ahead
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_orig_mem[i_addr] <= i_cell;
            // a one-cell row reads back the cell written in this cycle
            if (i_nxt_addr == i_addr) begin
                r_right <= i_cell;
            end else begin
                r_right <= r_orig_mem[i_nxt_addr];
            end
        end
    end

    // Filtered row: written from the result stage, read at accept
    always_ff @(posedge i_clk) begin
        if (i_fwe) begin
            r_filt_mem[i_faddr] <= i_fdata;
        end
        if (i_acc) begin
            r_up <= r_filt_mem[i_addr];
        end
    end

    assign o_up    = r_up;
    assign o_right = r_right;

endmodule

### sv/isolated_cell_fill_filter.sv
// ----------------------------------------------------------------------------
// isolated_cell_fill_filter
// In-place isolated cell fill over a raster of byte cells.
// ----------------------------------------------------------------------------
// Usage:
//   Cells enter in raster order on i_in_valid / o_in_stall, one per item.
//   Results leave on o_out_valid / i_out_stall with column, row, run_last
//   and grid_done. Row r-1 is given out while row r arrives, one result per
//   input; the last row also gives out each cell as it arrives (two results
//   per input), and the first row of a taller grid gives none.
//   An accepted item moves into the result stage and its result into the output
//   register; on the last row a second result follows the first into it.
//   Throughput: one item per cycle while the receiver does not stall; on the
//   last row of a taller grid an item holds the input until both its results
//   have entered the single output register, which takes one result per cycle.
//   Line buffer reads are registered at accept, so each stage holds one item.
//   Reset clears the raster position and the grid registers to 80 x 24; the
//   line buffers keep whatever they hold and are always written before read.
//   A configuration write restarts the grid; write only while idle.
//   When the receiver stalls, the output register holds its result and the
//   input side stalls once the result stage holds an item with a result.
// ----------------------------------------------------------------------------
module isolated_cell_fill_filter #(
    parameter int MAX_WIDTH = icf_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [icf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [icf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [icf_pkg::CELL_W-1:0]      i_cell_in,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [icf_pkg::CELL_W-1:0]      o_cell_out,
    output logic [icf_pkg::COL_OUT_W-1:0]   o_out_col,
    output logic [icf_pkg::ROW_W-1:0]       o_out_row,
    output logic                            o_run_last,
    output logic                            o_grid_done
);
    import icf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RST_W_EFF =
        (GRID_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_WIDTH_RST;
    localparam logic [AW-1:0]    RST_COL_LAST = AW'(RST_W_EFF - 1);
    localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(GRID_HEIGHT_RST - 1);

    // grid shape and raster position
    logic [AW-1:0]    r_col_last;
    logic [ROW_W-1:0] r_row_last;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CELL_W-1:0] r_left;

    // result stage
    logic              r_b_vld;
    logic              r_b_phase;
    logic [CELL_W-1:0] r_b_cell;
    logic [CELL_W-1:0] r_b_self;
    logic [AW-1:0]     r_b_x;
    logic [ROW_W-1:0]  r_b_r;
    logic              r_b_has_prev;
    logic              r_b_last_row;
    logic              r_b_final;
    logic              r_b_interior;

    // output register
    logic              r_o_vld;
    logic [CELL_W-1:0] r_o_cell;
    logic [AW-1:0]     r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic              r_o_run_last;
    logic              r_o_done;

    logic              acc;
    logic              out_free;
    logic              b_emit;
    logic              b_leave;
    logic              b_two;
    logic              sel_filt;
    logic              fill;
    logic [CELL_W-1:0] filt;
    logic [CELL_W-1:0] lb_up;
    logic [CELL_W-1:0] lb_right;
    logic [AW-1:0]     nxt_col;
    logic [GRID_WIDTH_W-1:0] cfg_w;
    logic [AW-1:0]     n_col_last;
    logic [CELL_W-1:0] n_o_cell;
    logic [ROW_W-1:0]  n_o_row;

    // Handshake and result stage control
    assign out_free = !r_o_vld || !i_out_stall;
    assign b_two    = r_b_has_prev && r_b_last_row;
    assign b_emit   = r_b_vld && (r_b_has_prev || r_b_last_row) && out_free;
    assign b_leave  = r_b_vld &&
                      ((!r_b_has_prev && !r_b_last_row) ||
                       (out_free && (r_b_phase || !b_two)));
    assign o_in_stall = r_b_vld && !b_leave;
    assign acc        = i_in_valid && !o_in_stall;
    assign nxt_col    = (r_col == r_col_last) ? '0 : r_col + 1'b1;

    // Line buffers
    icf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_acc      (acc),
        .i_addr     (r_col),
        .i_nxt_addr (nxt_col),
        .i_cell     (i_cell_in),
        .i_fwe      (b_emit && sel_filt),
        .i_faddr    (r_b_x),
        .i_fdata    (filt),
        .o_up       (lb_up),
        .o_right    (lb_right)
    );

    // Fill decision: an interior cell whose four neighbors agree and differ from it
    assign fill = r_b_interior && (lb_up == r_left) && (lb_up == lb_right) &&
                  (lb_up == r_b_cell) && (lb_up != r_b_self);
    assign filt = fill ? lb_up : r_b_self;

    // Pick the result: filtered cell of the row above first, then the cell
    assign sel_filt = !r_b_phase && r_b_has_prev;
    assign n_o_cell = sel_filt ? filt : r_b_cell;
    assign n_o_row  = sel_filt ? r_b_r - 1'b1 : r_b_r;

    // Decode a width write: zero counts as one, clip at the buffer depth
    assign cfg_w = i_cfg_data[GRID_WIDTH_W-1:0];
    always_comb begin
        if (cfg_w == '0) begin
            n_col_last = '0;
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            n_col_last = AW'(MAX_WIDTH - 1);
        end else begin
            n_col_last = AW'(cfg_w - 1'b1);
        end
    end

    // Configuration and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= RST_COL_LAST;
            r_row_last <= RST_ROW_LAST;
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_WIDTH: begin
                    r_col_last <= n_col_last;
                end
                CFG_GRID_HEIGHT: begin
                    r_row_last <= (i_cfg_data == '0) ? '0 : i_cfg_data - 1'b1;
                end
                default: begin
                end
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            // advance the raster position
            if (acc) begin
                r_col <= nxt_col;
                if (r_col == r_col_last) begin
                    r_row <= (r_row == r_row_last) ? '0 : r_row + 1'b1;
                end
            end
            // hold the filtered cell for the next column
            if (b_emit && sel_filt) begin
                r_left <= filt;
            end
        end
    end

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_b_phase <= 1'b0;
        end else begin
            if (acc) begin
                r_b_vld <= 1'b1;
            end else if (b_leave) begin
                r_b_vld <= 1'b0;
            end
            if (b_leave) begin
                r_b_phase <= 1'b0;
            end else if (b_emit && b_two) begin
                r_b_phase <= 1'b1;
            end
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_cell     <= i_cell_in;
            r_b_self     <= lb_right;
            r_b_x        <= r_col;
            r_b_r        <= r_row;
            r_b_has_prev <= (r_row != '0);
            r_b_last_row <= (r_row == r_row_last);
            r_b_final    <= (r_row == r_row_last) && (r_col == r_col_last);
            r_b_interior <= (r_row > ROW_W'(1)) && (r_col != '0) &&
                            (r_col < r_col_last);
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_emit) begin
            r_o_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (b_emit) begin
            r_o_cell     <= n_o_cell;
            r_o_col      <= r_b_x;
            r_o_row      <= n_o_row;
            r_o_run_last <= sel_filt ? !r_b_last_row : 1'b1;
            r_o_done     <= sel_filt ? 1'b0 : r_b_final;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_cell_out  = r_o_cell;
    assign o_out_col   = COL_OUT_W'(r_o_col);
    assign o_out_row   = r_o_row;
    assign o_run_last  = r_o_run_last;
    assign o_grid_done = r_o_done;

    // The second result of an item exists only on the last row
    a_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && r_b_phase |-> r_b_has_prev && r_b_last_row)
        else $error("second result pending outside the last row");

    // The final cell of the grid sits at the last column and row
    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_done |-> (r_o_col == r_col_last) &&
                                (r_o_row == r_row_last) && r_o_run_last)
        else $error("grid end flagged away from the last cell");

    // The raster position stays inside the grid
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("raster position outside the grid");

    // An item that leaves with a result pending never loses it
    a_emit_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_leave && (r_b_has_prev || r_b_last_row) |-> b_emit)
        else $error("item left the result stage without its result");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the isolated cell fill filter. A short table of
// cells and grid settings runs first, then grids of many sizes, most of them random. Every
// accepted cell goes through a local model of the in-place fill, and each
// emitted cell is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import icf_pkg::*;

    localparam int MAXW          = DEF_MAX_WIDTH;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RAND_ITEMS    = 1200;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [CELL_W-1:0]    value;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 run_last;
        logic                 grid_done;
    } cell_res_t;

    typedef enum logic [1:0] {STEP_CELL, STEP_WIDTH, STEP_HEIGHT} step_e;

    typedef struct packed {
        step_e                 kind;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        cell_res_t             want;
    } dir_row_t;

    localparam cell_res_t NO_RES = '0;
    localparam int DIR_N = 26;

    // Directed rows: reset setting, one-row grids, clamped sizes, a small fill
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{STEP_CELL,   16'h0011, 1'b0, NO_RES},
        '{STEP_CELL,   16'h00EE, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0000, 1'b0, NO_RES},
        '{STEP_WIDTH,  16'd3,    1'b0, NO_RES},
        '{STEP_HEIGHT, 16'd1,    1'b0, NO_RES},
        '{STEP_CELL,   16'h0000, 1'b1, '{8'h00, 8'd0, 16'd0, 1'b1, 1'b0}},
        '{STEP_CELL,   16'h00FF, 1'b1, '{8'hFF, 8'd1, 16'd0, 1'b1, 1'b0}},
        '{STEP_CELL,   16'h005A, 1'b1, '{8'h5A, 8'd2, 16'd0, 1'b1, 1'b1}},
        '{STEP_WIDTH,  16'd0,    1'b0, NO_RES},
        '{STEP_CELL,   16'h00A5, 1'b1, '{8'hA5, 8'd0, 16'd0, 1'b1, 1'b1}},
        '{STEP_HEIGHT, 16'd0,    1'b0, NO_RES},
        '{STEP_CELL,   16'h003C, 1'b1, '{8'h3C, 8'd0, 16'd0, 1'b1, 1'b1}},
        '{STEP_WIDTH,  16'd4,    1'b0, NO_RES},
        '{STEP_HEIGHT, 16'd3,    1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0002, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0004, 1'b0, NO_RES},
        '{STEP_CELL,   16'h0009, 1'b0, NO_RES}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CELL_W-1:0]     i_cell_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CELL_W-1:0]     o_cell_out;
    logic [COL_OUT_W-1:0]  o_out_col;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_run_last;
    logic                  o_grid_done;

    // Model state: line buffers, left neighbor, raster position, grid size
    logic [CELL_W-1:0]       filt_line [MAXW];
    logic [CELL_W-1:0]       orig_line [MAXW];
    logic [CELL_W-1:0]       left_fill;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic [GRID_WIDTH_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0]   height_reg;

    cell_res_t pending_cells [$];
    int        errors        = 0;
    int        results_seen  = 0;
    int        cells_sent    = 0;
    int        fills_seen    = 0;
    int        settings_seen = 0;
    int        quiet_cycles  = 0;
    bit        calm          = 1'b0;
    bit        hold_req      = 1'b0;

    isolated_cell_fill_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cell_in   (i_cell_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell_out  (o_cell_out),
        .o_out_col   (o_out_col),
        .o_out_row   (o_out_row),
        .o_run_last  (o_run_last),
        .o_grid_done (o_grid_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s at result %0d: got %0d want %0d", what, results_seen, got,
                 want);
    endtask

    // Queue one expected result behind the ones already waiting
    task automatic queue_result(input cell_res_t res);
        pending_cells = {pending_cells, res};
    endtask

    // Write a grid register into the model; any write restarts the grid
    task automatic load_grid_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_GRID_WIDTH) begin
            width_reg = data[GRID_WIDTH_W-1:0];
        end else begin
            height_reg = data;
        end
        left_fill = '0;
        col_pos   = 0;
        row_pos   = 0;
        settings_seen++;
    endtask

    // Finish the cell above the incoming one, and echo the incoming one on the last row
    task automatic fill_cell(input logic [CELL_W-1:0] cell_v, output cell_res_t res_a,
                             output cell_res_t res_b, output int n);
        int unsigned       w;
        int unsigned       h;
        int unsigned       x;
        int unsigned       r;
        logic              last_row;
        logic [CELL_W-1:0] center_v;
        logic [CELL_W-1:0] up_v;
        logic [CELL_W-1:0] f;
        cell_res_t         res;
        w = (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        x = col_pos;
        r = row_pos;
        last_row = (r + 1 == h);
        n = 0;
        res_a = '0;
        res_b = '0;
        if (r >= 1) begin
            center_v = orig_line[x];
            up_v = filt_line[x];
            f = center_v;
            // take the neighbors' value when all four agree on another one
            if (r >= 2 && x >= 1 && x + 1 < w && up_v == left_fill
                && up_v == orig_line[x + 1] && up_v == cell_v && up_v != center_v) begin
                f = up_v;
                fills_seen++;
            end
            filt_line[x] = f;
            left_fill = f;
            res.value = f;
            res.col = x[COL_OUT_W-1:0];
            res.row = ROW_W'(r - 1);
            res.run_last = !last_row;
            res.grid_done = 1'b0;
            res_a = res;
            n = 1;
        end
        orig_line[x] = cell_v;
        if (last_row) begin
            res.value = cell_v;
            res.col = x[COL_OUT_W-1:0];
            res.row = ROW_W'(r);
            res.run_last = 1'b1;
            res.grid_done = (x + 1 == w);
            if (n == 0) res_a = res;
            else res_b = res;
            n++;
        end
        // advance raster position, wrapping at the end of the grid
        col_pos = x + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // Offer one cell, with a random gap in front, and record what it must cause
    task automatic send_cell(input logic [CELL_W-1:0] v, input logic typed,
                             input cell_res_t want);
        cell_res_t ra;
        cell_res_t rb;
        int        n;
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_in  <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fill_cell(v, ra, rb, n);
        if (typed) begin
            queue_result(want);
        end else begin
            if (n > 0) queue_result(ra);
            if (n > 1) queue_result(rb);
        end
        cells_sent++;
        @(negedge i_clk);
    endtask

    // Hold input until every expected result is out, then let the pipe empty
    task automatic settle_all();
        int k;
        i_in_valid <= 1'b0;
        for (k = 0; k < QUIET_LIMIT && pending_cells.size() != 0; k++) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        load_grid_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // One grid setting with whole or partial grids of mostly flat content
    task automatic run_phase(input int phase);
        int unsigned           w;
        int unsigned           h;
        int unsigned           total;
        int unsigned           n_cells;
        int unsigned           k;
        logic [CELL_W-1:0]     bg;
        logic [CFG_DATA_W-1:0] wdata;
        bit                    noisy;
        if (phase == 1) begin
            w = 511;
            h = 2;
        end else if (phase == 2) begin
            w = 3;
            h = 65535;
        end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) w = 0;
            if ($urandom_range(0, 9) == 0) h = 0;
        end
        // unused upper bits of the width write carry random values
        wdata = CFG_DATA_W'(w) | (CFG_DATA_W'($urandom_range(0, 127)) << GRID_WIDTH_W);
        settle_all();
        write_reg(CFG_GRID_WIDTH, wdata);
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
        total = ((w == 0) ? 1 : (w > MAXW) ? MAXW : w) * ((h == 0) ? 1 : h);
        if (phase == 1) n_cells = total;
        else if (phase == 2) n_cells = 40;
        else n_cells = total * $urandom_range(1, 3);
        if (phase > 2 && total > 1 && $urandom_range(0, 4) == 0)
            n_cells = $urandom_range(1, total - 1);
        noisy = ($urandom_range(0, 5) == 0);
        bg = CELL_W'($urandom_range(0, 255));
        if (phase == 1) begin
            hold_req = 1'b1;
            calm = 1'b1;
        end
        for (k = 0; k < n_cells; k++) begin
            if (phase == 3 && k == n_cells / 2) settle_all();
            if (noisy || $urandom_range(0, 99) < 30)
                send_cell(CELL_W'($urandom_range(0, 255)), 1'b0, NO_RES);
            else
                send_cell(bg, 1'b0, NO_RES);
        end
        calm = 1'b0;
    endtask

    // Output side stall: random, with one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 30);
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        cell_res_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected result, cell", o_cell_out, -1);
            end else begin
                want = pending_cells.pop_front();
                if (o_cell_out !== want.value)
                    report_mismatch("cell_out", o_cell_out, want.value);
                if (o_out_col !== want.col)
                    report_mismatch("out_col", o_out_col, want.col);
                if (o_out_row !== want.row)
                    report_mismatch("out_row", o_out_row, want.row);
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", o_run_last, want.run_last);
                if (o_grid_done !== want.grid_done)
                    report_mismatch("grid_done", o_grid_done, want.grid_done);
            end
            results_seen++;
        end
    end

    // Count cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAILED: results differ");
        $finish;
    end

    // Reset, directed table, random grids, drain
    initial begin
        int start_cells;
        int phase;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_cell_in  = '0;
        width_reg  = GRID_WIDTH_W'(GRID_WIDTH_RST);
        height_reg = CFG_DATA_W'(GRID_HEIGHT_RST);
        left_fill  = '0;
        col_pos    = 0;
        row_pos    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_ROWS[i].kind == STEP_CELL) begin
                send_cell(DIR_ROWS[i].data[CELL_W-1:0], DIR_ROWS[i].typed,
                          DIR_ROWS[i].want);
            end else begin
                settle_all();
                write_reg(DIR_ROWS[i].kind == STEP_WIDTH ? CFG_GRID_WIDTH : CFG_GRID_HEIGHT,
                          DIR_ROWS[i].data);
            end
        end

        start_cells = cells_sent;
        phase = 0;
        while (cells_sent - start_cells < RAND_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        settle_all();
        repeat (8) @(negedge i_clk);
        if (pending_cells.size() != 0)
            report_mismatch("results never seen, count", 0, pending_cells.size());

        $display("Sent %0d cells over %0d register writes, widths 0..511, heights 0..65535.",
                 cells_sent, settings_seen);
        $display("Checked %0d results, %0d isolated cells filled.", results_seen,
                 fills_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
